@@ src/tcw_pkg.sv @@
// Package for the text console writer: field widths, character codes,
// controller states and the command/status structs between the controller
// and the datapath. No dependencies.
package tcw_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Item field widths
    localparam int MODE_W     = 1;
    localparam int CHAR_W     = 8;
    localparam int COLOR_W    = 4;
    localparam int INDEX_W    = 11;
    localparam int CELL_W     = 16;
    localparam int ROW_OUT_W  = 5;
    localparam int COL_OUT_W  = 7;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_PUT  = 1'b0;
    localparam logic [MODE_W-1:0] MODE_READ = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_PUT,
        S_SCROLL,
        S_DRAIN,
        S_FILL,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic load_item;  // latch the accepted item
        logic clr_wr;     // write zero at the sweep counter
        logic put_wr;     // write the character at the cursor
        logic fill_wr;    // write a blank into the last row
        logic scroll_rd;  // read one row down for the scroll copy
        logic rd_cell;    // read the requested cell
        logic cnt_clr;
        logic cnt_inc;
        logic col_zero;
        logic row_inc;
        logic col_inc;
        logic back;       // step the cursor back one cell
        logic rep_tab;
        logic rep_one;
        logic rep_dec;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic is_nl;
        logic is_bs;
        logic is_tab;
        logic wrap;        // column has reached the right edge
        logic last_row;
        logic clear_last;
        logic scroll_last;
        logic fill_last;
        logic rep_last;
        logic out_free;
    } t_status;

endpackage

@@ src/tcw_ctrl.sv @@
// Controller of the text console writer: sequences clearing, dispatch,
// character writes, scrolling and result hand-off. Depends on tcw_pkg.
module tcw_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  tcw_pkg::t_status i_status,
    output logic            o_in_ready,
    output tcw_pkg::t_cmd    o_cmd
);
    import tcw_pkg::*;

    t_state r_state, n_state;
    logic   r_put_ret, n_put_ret;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_put_ret <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_put_ret <= n_put_ret;
        end
    end

    // Next state
    always_comb begin
        n_state   = r_state;
        n_put_ret = r_put_ret;
        unique case (r_state)
            S_CLEAR: begin
                if (i_status.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                priority if (i_status.is_read) begin
                    n_state = S_RESULT;
                end else if (i_status.is_nl) begin
                    if (i_status.last_row) begin
                        n_state   = S_SCROLL;
                        n_put_ret = 1'b0;
                    end else begin
                        n_state = S_RESULT;
                    end
                end else if (i_status.is_bs) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                priority if (i_status.wrap && i_status.last_row) begin
                    n_state   = S_SCROLL;
                    n_put_ret = 1'b1;
                end else if (i_status.wrap) begin
                    n_state = S_PUT;
                end else if (i_status.rep_last) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_SCROLL: begin
                if (i_status.scroll_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_FILL;
            end
            S_FILL: begin
                if (i_status.fill_last) n_state = r_put_ret ? S_PUT : S_RESULT;
            end
            S_RESULT: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                o_cmd.cnt_clr = i_status.clear_last;
            end
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            S_DISPATCH: begin
                priority if (i_status.is_read) begin
                    o_cmd.rd_cell = 1'b1;
                end else if (i_status.is_nl) begin
                    o_cmd.col_zero = 1'b1;
                    o_cmd.row_inc  = !i_status.last_row;
                    o_cmd.cnt_clr  = i_status.last_row;
                end else if (i_status.is_bs) begin
                    o_cmd.back = 1'b1;
                end else if (i_status.is_tab) begin
                    o_cmd.rep_tab = 1'b1;
                end else begin
                    o_cmd.rep_one = 1'b1;
                end
            end
            S_PUT: begin
                if (i_status.wrap) begin
                    o_cmd.col_zero = 1'b1;
                    o_cmd.row_inc  = !i_status.last_row;
                    o_cmd.cnt_clr  = i_status.last_row;
                end else begin
                    o_cmd.put_wr  = 1'b1;
                    o_cmd.col_inc = 1'b1;
                    o_cmd.rep_dec = 1'b1;
                end
            end
            S_SCROLL: begin
                o_cmd.scroll_rd = 1'b1;
                o_cmd.cnt_inc   = 1'b1;
                o_cmd.cnt_clr   = i_status.scroll_last;
            end
            S_DRAIN: begin
                o_cmd = '0;
            end
            S_FILL: begin
                o_cmd.fill_wr = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                o_cmd.cnt_clr = i_status.fill_last;
            end
            S_RESULT: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ src/tcw_datapath.sv @@
// Datapath of the text console writer: cell store, cursor, sweep and repeat
// counters, item and result registers. Depends on tcw_pkg.
module tcw_datapath #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tcw_pkg::t_cmd                     i_cmd,
    output tcw_pkg::t_status                  o_status,
    input  logic [tcw_pkg::MODE_W-1:0]        i_mode,
    input  logic [tcw_pkg::CHAR_W-1:0]        i_char_code,
    input  logic [tcw_pkg::COLOR_W-1:0]       i_fg_color,
    input  logic [tcw_pkg::COLOR_W-1:0]       i_bg_color,
    input  logic [tcw_pkg::INDEX_W-1:0]       i_cell_index,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [tcw_pkg::OUT_TDATA_W-1:0]   o_out_data
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int RW         = $clog2(ROWS);
    localparam int CW         = $clog2(COLUMNS + 1);
    localparam int PAD_W      = OUT_TDATA_W - CELL_W - ROW_OUT_W - COL_OUT_W;

    logic [CELL_W-1:0] r_mem [CELL_COUNT];
    logic [CELL_W-1:0] r_rdata;

    // Latched item
    logic [MODE_W-1:0]  r_mode;
    logic [CHAR_W-1:0]  r_char;
    logic [COLOR_W-1:0] r_fg;
    logic [COLOR_W-1:0] r_bg;
    logic [INDEX_W-1:0] r_idx;

    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [AW-1:0] r_cnt;
    logic [2:0]    r_rep;
    logic          r_cp_valid;
    logic [AW-1:0] r_cp_addr;
    logic          r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [CHAR_W*2-1:0] attr_hi;
    logic                in_range;
    logic [AW-1:0]       cur_addr;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [CELL_W-1:0]   wr_data;
    logic [CHAR_W-1:0]   put_char;
    logic [CELL_W-1:0]   cell_out;

    assign attr_hi  = {r_bg, r_fg, {CHAR_W{1'b0}}};
    assign in_range = 32'(r_idx) < CELL_COUNT;
    assign cur_addr = AW'(32'(r_row) * COLUMNS + 32'(r_col));
    assign put_char = (r_char == CH_TAB) ? CH_SPACE : r_char;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_mode <= i_mode;
            r_char <= i_char_code;
            r_fg   <= i_fg_color;
            r_bg   <= i_bg_color;
            r_idx  <= i_cell_index;
        end
    end

    // Read port: a scroll read looks one row down, otherwise the requested cell
    always_comb begin
        if (i_cmd.scroll_rd) begin
            rd_addr = AW'(32'(r_cnt) + COLUMNS);
        end else if (in_range) begin
            rd_addr = AW'(r_idx);
        end else begin
            rd_addr = '0;
        end
    end

    // Write port
    always_comb begin
        wr_en   = 1'b1;
        wr_addr = cur_addr;
        wr_data = {attr_hi[CELL_W-1:CHAR_W], put_char};
        priority if (i_cmd.clr_wr) begin
            wr_addr = r_cnt;
            wr_data = '0;
        end else if (r_cp_valid) begin
            wr_addr = r_cp_addr;
            wr_data = r_rdata;
        end else if (i_cmd.fill_wr) begin
            wr_addr = AW'(COPY_COUNT + 32'(r_cnt));
            wr_data = attr_hi;
        end else if (i_cmd.put_wr) begin
            wr_addr = cur_addr;
        end else begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_cell || i_cmd.scroll_rd) r_rdata <= r_mem[rd_addr];
    end

    // Pending scroll write follows its read in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp_valid <= 1'b0;
        end else begin
            r_cp_valid <= i_cmd.scroll_rd;
        end
        r_cp_addr <= r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep <= '0;
        end else if (i_cmd.rep_tab) begin
            r_rep <= 3'd4;
        end else if (i_cmd.rep_one) begin
            r_rep <= 3'd1;
        end else if (i_cmd.rep_dec) begin
            r_rep <= r_rep - 1'b1;
        end
    end

    // Cursor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            if (i_cmd.col_zero) begin
                r_col <= '0;
            end else if (i_cmd.col_inc) begin
                r_col <= r_col + 1'b1;
            end else if (i_cmd.back) begin
                if (r_col != '0) begin
                    r_col <= r_col - 1'b1;
                end else if (r_row != '0) begin
                    r_col <= CW'(COLUMNS - 1);
                end
            end
            if (i_cmd.row_inc) begin
                r_row <= r_row + 1'b1;
            end else if (i_cmd.back && r_col == '0 && r_row != '0) begin
                r_row <= r_row - 1'b1;
            end
        end
    end

    // Result register
    assign cell_out = (r_mode == MODE_READ && in_range) ? r_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {{PAD_W{1'b0}}, COL_OUT_W'(r_col), ROW_OUT_W'(r_row), cell_out};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_status.is_read     = (r_mode == MODE_READ);
    assign o_status.is_nl       = (r_char == CH_NEWLINE);
    assign o_status.is_bs       = (r_char == CH_BACKSPACE);
    assign o_status.is_tab      = (r_char == CH_TAB);
    assign o_status.wrap        = (32'(r_col) == COLUMNS);
    assign o_status.last_row    = (32'(r_row) == ROWS - 1);
    assign o_status.clear_last  = (32'(r_cnt) == CELL_COUNT - 1);
    assign o_status.scroll_last = (32'(r_cnt) == COPY_COUNT - 1);
    assign o_status.fill_last   = (32'(r_cnt) == COLUMNS - 1);
    assign o_status.rep_last    = (r_rep == 3'd1);
    assign o_status.out_free    = !r_out_valid || i_out_ready;

endmodule

@@ src/text_console_writer_top.sv @@
// Top level of the text console writer: stream ports, controller and
// datapath. Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
//
// Usage:
//   Input items arrive on the slave stream. tuser carries the mode
//   (0 = put a character at the cursor, 1 = read one screen cell); tdata
//   carries the character, colors and cell index. Every item gives exactly
//   one result on the master stream: the read cell (0 for puts and for an
//   index beyond the screen) and the cursor row and column after the item.
//   Items are handled one at a time. A read, a backspace or a newline
//   without scroll goes from dispatch straight to the result; an ordinary
//   character writes one cell and a tab writes four spaces before the result.
//   A scroll copies each cell one row up, one cell a cycle, then blanks the
//   last row; all of it goes through the single write port of the cell store.
//   tready rises again in the cycle after the previous result is loaded.
//   Reset: the store is swept to zero; tready stays low until the sweep
//   finishes. The cursor goes to 0,0.
//   Stall: the result waits in the output register; the engine holds in its
//   result state until the register frees, then takes the next item.
module text_console_writer_top #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata: char_code[7:0], fg_color[11:8], bg_color[15:12],
    //        cell_index[26:16], zero [31:27]
    input  logic [tcw_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // tuser: mode[0]
    input  logic [tcw_pkg::MODE_W-1:0]       i_s_axis_tuser,
    // Result stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // tdata: cell_data[15:0], cursor_row[20:16], cursor_col[27:21], zero [31:28]
    output logic [tcw_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import tcw_pkg::*;

    t_cmd    cmd;
    t_status status;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_status   (status),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    // Unpack the input item fields from the low bits up
    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_mode       (i_s_axis_tuser),
        .i_char_code  (i_s_axis_tdata[CHAR_W-1:0]),
        .i_fg_color   (i_s_axis_tdata[CHAR_W +: COLOR_W]),
        .i_bg_color   (i_s_axis_tdata[CHAR_W+COLOR_W +: COLOR_W]),
        .i_cell_index (i_s_axis_tdata[CHAR_W+2*COLOR_W +: INDEX_W]),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_out_data   (o_m_axis_tdata)
    );

endmodule
